// ===== design/mau_pkg.sv =====
// Package for the modular arithmetic unit: constants, opcodes, payload structs.
// No dependencies.
package mau_pkg;

	localparam int unsigned RESIDUE_BITS = 31;
	localparam int unsigned WIDE_BITS    = 64;
	localparam logic [RESIDUE_BITS-1:0] MODULUS_RESET = 31'd1000000007;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_INV  = 4'd4,
		OP_POW  = 4'd5,
		OP_NEG  = 4'd6,
		OP_INC  = 4'd7,
		OP_DEC  = 4'd8,
		OP_REDS = 4'd9,
		OP_REDU = 4'd10
	} op_t;

	typedef struct packed {
		logic [3:0]              op;
		logic [RESIDUE_BITS-1:0] left_operand;
		logic [RESIDUE_BITS-1:0] right_operand;
		logic [WIDE_BITS-1:0]    wide_value;
	} cmd_t;

	typedef struct packed {
		logic [RESIDUE_BITS-1:0] residue;
		logic                    error;
	} rsp_t;

endpackage

// ===== design/mau_mulmod.sv =====
// Bit-serial modular multiplier: (a*b) mod m, one bit of b per cycle, MSB first.
// Depends on mau_pkg (nothing beyond width parameter here).
module mau_mulmod #(
	parameter int unsigned W = mau_pkg::RESIDUE_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] p
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [W:0]    dbl;
	logic [W:0]    dbl_r;
	logic [W:0]    add;

	// acc = 2*acc mod m, then + a if the bit is set
	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		add   = dbl_r + (b_q[W-1] ? {1'b0, a_q} : '0);
		if (add >= {1'b0, m}) begin
			add = add - {1'b0, m};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (run_q) begin
			acc_q <= add[W-1:0];
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule

// ===== design/mau_divmod.sv =====
// Restoring bit-serial divider: quotient and remainder of n / d, one bit per cycle.
// Dividend is NW bits wide. Depends on nothing.
module mau_divmod #(
	parameter int unsigned NW = 64,
	parameter int unsigned DW = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   sh;
	logic          ge;

	assign sh = {r_q, q_q[NW-1]};
	assign ge = (sh >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= n;
			r_q <= '0;
			d_q <= d;
		end else if (run_q) begin
			r_q <= ge ? DW'(sh - {1'b0, d_q}) : sh[DW-1:0];
			q_q <= {q_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;
endmodule

// ===== design/modular_arithmetic_unit.sv =====
// Modular arithmetic unit top level: command sequencer around a bit-serial
// multiplier and divider. Depends on mau_pkg, mau_mulmod, mau_divmod.
//
// One command at a time: busy rises once a start is accepted and stays high
// through the result strobe cycle, so the next start is taken in the cycle
// after the strobe. Add, sub, neg, inc, dec and errors found at dispatch go
// straight to the result; mul runs one multiply; the reductions run one
// division. Each step of the inverse iteration runs a division, then a
// multiply; div adds one more multiply. Pow runs a multiply and a square for
// each set exponent bit (no square after the last one) and a square for each
// clear bit; a negative exponent runs the inverse first. The result is shown
// for one cycle with done high and cannot be stalled. Config writes are taken
// while idle.
module modular_arithmetic_unit #(
	parameter int unsigned RESIDUE_BITS = mau_pkg::RESIDUE_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  mau_pkg::cmd_t           cmd,
	output logic                    done,
	output mau_pkg::rsp_t           rsp,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [RESIDUE_BITS-1:0] cfg_data
);
	localparam int unsigned W  = RESIDUE_BITS;
	localparam int unsigned WB = mau_pkg::WIDE_BITS;
	localparam int unsigned OW = 31;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISP, ST_RED, ST_INV_DIV, ST_INV_MUL, ST_DIV_MUL,
		ST_POW_BIT, ST_POW_MR, ST_POW_SQ, ST_OUT
	} state_t;

	state_t         state_q;
	logic [W-1:0]   mod_q;
	logic [3:0]     op_q;
	logic [W-1:0]   a_q;
	logic [W-1:0]   b_q;
	logic [WB-1:0]  w_q;
	logic [W-1:0]   prod_q;
	logic [W-1:0]   v_q;
	logic [W-1:0]   base_q;
	logic [WB-1:0]  e_q;
	logic [W-1:0]   res_q;
	logic           err_q;
	logic           done_q;
	logic [W-1:0]   one_m;

	logic           mul_start;
	logic [W-1:0]   mul_a;
	logic [W-1:0]   mul_b;
	logic           mul_done;
	logic [W-1:0]   mul_p;
	logic           div_start;
	logic [WB-1:0]  div_n;
	logic [W-1:0]   div_d;
	logic           div_done;
	logic [WB-1:0]  div_quo;
	logic [W-1:0]   div_rem;

	logic [W-1:0]   opa;
	logic [W-1:0]   opb;
	logic [W:0]     sum;
	logic [W:0]     inc;
	logic           a_bad;
	logic           b_bad;
	logic [WB-1:0]  w_mag;

	logic           div_inv;
	logic           mul_go_q;
	logic           div_go_q;
	logic [W-1:0]   mul_a_q;
	logic [W-1:0]   mul_b_q;
	logic [W-1:0]   inv_fac;

	assign opa   = W'(cmd.left_operand);
	assign opb   = W'(cmd.right_operand);
	assign one_m = (mod_q == W'(1)) ? '0 : W'(1);
	assign sum   = {1'b0, a_q} + {1'b0, b_q};
	assign inc   = {1'b0, a_q} + 1'b1;
	assign a_bad = (a_q >= mod_q);
	assign b_bad = (b_q >= mod_q);
	assign w_mag = (op_q == mau_pkg::OP_REDS && w_q[WB-1]) ? WB'(0) - w_q : w_q;

	// one divider: m / v for the inverse, |w| / m for the reductions
	assign div_inv = (state_q == ST_INV_DIV);
	assign div_n   = div_inv ? WB'(mod_q) : w_mag;
	assign div_d   = div_inv ? v_q : mod_q;

	// mul and div launch on state entry pulses
	assign mul_start = mul_go_q;
	assign mul_a     = mul_a_q;
	assign mul_b     = mul_b_q;
	assign div_start = div_go_q;

	assign inv_fac = W'(WB'(mod_q) - div_quo);

	mau_mulmod #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.m(mod_q), .done(mul_done), .p(mul_p)
	);

	mau_divmod #(.NW(WB), .DW(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .n(div_n), .d(div_d),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mod_q    <= W'(mau_pkg::MODULUS_RESET);
			done_q   <= 1'b0;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				mod_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start && !busy) begin
						op_q    <= cmd.op;
						a_q     <= opa;
						b_q     <= opb;
						w_q     <= cmd.wide_value;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					err_q   <= 1'b0;
					res_q   <= '0;
					state_q <= ST_OUT;
					prod_q  <= one_m;
					if (mod_q == '0 || op_q > mau_pkg::OP_REDU) begin
						err_q <= 1'b1;
					end else if (op_q <= mau_pkg::OP_DIV && (a_bad || b_bad)) begin
						err_q <= 1'b1;
					end else if (op_q >= mau_pkg::OP_INV && op_q <= mau_pkg::OP_DEC && a_bad) begin
						err_q <= 1'b1;
					end else begin
						unique case (op_q)
							mau_pkg::OP_ADD: res_q <= (sum >= {1'b0, mod_q}) ?
								W'(sum - {1'b0, mod_q}) : sum[W-1:0];
							mau_pkg::OP_SUB: res_q <= (a_q >= b_q) ? a_q - b_q :
								a_q + (mod_q - b_q);
							mau_pkg::OP_MUL: begin
								mul_a_q  <= a_q;
								mul_b_q  <= b_q;
								mul_go_q <= 1'b1;
								state_q  <= ST_DIV_MUL;
							end
							mau_pkg::OP_DIV, mau_pkg::OP_INV: begin
								if ((op_q == mau_pkg::OP_DIV) ? (b_q == '0) : (a_q == '0)) begin
									err_q <= 1'b1;
								end else begin
									v_q <= (op_q == mau_pkg::OP_DIV) ? b_q : a_q;
									if (((op_q == mau_pkg::OP_DIV) ? b_q : a_q) == W'(1)) begin
										state_q <= ST_INV_MUL;
										mul_a_q <= one_m;
										mul_b_q <= one_m;
										mul_go_q <= 1'b1;
									end else begin
										div_go_q <= 1'b1;
										state_q  <= ST_INV_DIV;
									end
								end
							end
							mau_pkg::OP_POW: begin
								base_q <= a_q;
								e_q    <= w_q;
								if (w_q[WB-1]) begin
									if (a_q == '0) begin
										err_q <= 1'b1;
									end else begin
										e_q   <= WB'(0) - w_q;
										v_q   <= a_q;
										if (a_q == W'(1)) begin
											base_q  <= one_m;
											state_q <= ST_POW_BIT;
										end else begin
											div_go_q <= 1'b1;
											state_q  <= ST_INV_DIV;
										end
									end
								end else begin
									state_q <= ST_POW_BIT;
								end
							end
							mau_pkg::OP_NEG: res_q <= (a_q == '0) ? '0 : mod_q - a_q;
							mau_pkg::OP_INC: res_q <= (inc >= {1'b0, mod_q}) ? '0 : inc[W-1:0];
							mau_pkg::OP_DEC: res_q <= (a_q == '0) ? mod_q - 1'b1 : a_q - 1'b1;
							default: begin
								div_go_q <= 1'b1;
								state_q  <= ST_RED;
							end
						endcase
					end
				end
				ST_RED: begin
					if (div_done) begin
						if (op_q == mau_pkg::OP_REDS && w_q[WB-1] && div_rem != '0) begin
							res_q <= mod_q - div_rem;
						end else if (op_q == mau_pkg::OP_REDS && w_q[WB-1]) begin
							res_q <= '0;
						end else begin
							res_q <= div_rem;
						end
						state_q <= ST_OUT;
					end
				end
				ST_INV_DIV: begin
					if (div_done) begin
						mul_a_q  <= prod_q;
						mul_b_q  <= inv_fac;
						v_q      <= div_rem;
						mul_go_q <= 1'b1;
						state_q  <= ST_INV_MUL;
					end
				end
				ST_INV_MUL: begin
					if (mul_done) begin
						// pow restarts the running product once the base is inverted
						prod_q <= (v_q <= W'(1) && op_q == mau_pkg::OP_POW) ? one_m : mul_p;
						if (v_q > W'(1)) begin
							div_go_q <= 1'b1;
							state_q  <= ST_INV_DIV;
						end else if (op_q == mau_pkg::OP_DIV) begin
							mul_a_q  <= a_q;
							mul_b_q  <= mul_p;
							mul_go_q <= 1'b1;
							state_q  <= ST_DIV_MUL;
						end else if (op_q == mau_pkg::OP_POW) begin
							base_q  <= mul_p;
							state_q <= ST_POW_BIT;
						end else begin
							res_q   <= mul_p;
							state_q <= ST_OUT;
						end
					end
				end
				ST_DIV_MUL: begin
					if (mul_done) begin
						res_q   <= mul_p;
						state_q <= ST_OUT;
					end
				end
				ST_POW_BIT: begin
					if (e_q == '0) begin
						res_q   <= prod_q;
						state_q <= ST_OUT;
					end else if (e_q[0]) begin
						mul_a_q  <= prod_q;
						mul_b_q  <= base_q;
						mul_go_q <= 1'b1;
						state_q  <= ST_POW_MR;
					end else begin
						e_q      <= e_q >> 1;
						mul_a_q  <= base_q;
						mul_b_q  <= base_q;
						mul_go_q <= 1'b1;
						state_q  <= ST_POW_SQ;
					end
				end
				ST_POW_MR: begin
					if (mul_done) begin
						prod_q <= mul_p;
						e_q    <= e_q >> 1;
						if ((e_q >> 1) == '0) begin
							res_q   <= mul_p;
							state_q <= ST_OUT;
						end else begin
							mul_a_q  <= base_q;
							mul_b_q  <= base_q;
							mul_go_q <= 1'b1;
							state_q  <= ST_POW_SQ;
						end
					end
				end
				ST_POW_SQ: begin
					if (mul_done) begin
						base_q  <= mul_p;
						state_q <= ST_POW_BIT;
					end
				end
				ST_OUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE) || done_q;
	assign cfg_ready = !busy && !start;
	assign done      = done_q;
	assign rsp.residue = OW'(res_q);
	assign rsp.error   = err_q;
endmodule

// ===== design/mau_checker.sv =====
// Port-level checker for modular_arithmetic_unit, bound to the top level.
// Depends on mau_pkg.
module mau_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input mau_pkg::rsp_t rsp,
	input logic          cfg_valid,
	input logic          cfg_ready
);
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.error |-> rsp.residue == '0) else $error("error with nonzero residue");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("transfer not followed by busy");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !busy && !start)
		else $error("config transfer while busy or starting");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

// ===== tb/tb.sv =====
// Testbench for modular_arithmetic_unit: directed and random commands through several
// moduli, with a scoreboard that predicts every residue and error flag.
// Depends on mau_pkg and the modular_arithmetic_unit RTL.
`timescale 1ns / 100ps

class residue_scoreboard;
	mau_pkg::rsp_t expected_q[$];
	int unsigned failures;

	function new();
		failures = 0;
	endfunction

	static function longint unsigned mulmod(longint unsigned a, longint unsigned b,
			longint unsigned m);
		return (a * b) % m;
	endfunction

	// product of (m - m div v) terms, taking v to m mod v while v > 1
	static function longint unsigned invmod(longint unsigned x, longint unsigned m);
		longint unsigned prod;
		longint unsigned v;
		prod = 1 % m;
		v = x;
		if (v == 1) begin
			return prod;
		end
		do begin
			prod = mulmod(prod, m - m / v, m);
			v = m % v;
		end while (v > 1);
		return prod;
	endfunction

	static function longint unsigned powmod(longint unsigned base, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		acc = 1 % m;
		while (e > 0) begin
			if (e[0]) begin
				acc = mulmod(acc, base, m);
			end
			e = e >> 1;
			if (e > 0) begin
				base = mulmod(base, base, m);
			end
		end
		return acc;
	endfunction

	static function mau_pkg::rsp_t predict(mau_pkg::cmd_t c, logic [30:0] modulus);
		longint unsigned m, a, b, w, r, res;
		logic err;
		mau_pkg::rsp_t p;
		m = modulus;
		a = c.left_operand;
		b = c.right_operand;
		w = c.wide_value;
		res = 0;
		err = 1'b0;
		if (m == 0 || c.op > mau_pkg::OP_REDU) begin
			err = 1'b1;
		end else if (c.op <= mau_pkg::OP_DIV && (a >= m || b >= m)) begin
			err = 1'b1;
		end else if (c.op >= mau_pkg::OP_INV && c.op <= mau_pkg::OP_DEC && a >= m) begin
			err = 1'b1;
		end else begin
			case (mau_pkg::op_t'(c.op))
				mau_pkg::OP_ADD: begin
					res = a + b;
					if (res >= m) res -= m;
				end
				mau_pkg::OP_SUB: res = (a >= b) ? a - b : a + (m - b);
				mau_pkg::OP_MUL: res = mulmod(a, b, m);
				mau_pkg::OP_DIV: begin
					if (b == 0) err = 1'b1;
					else res = mulmod(a, invmod(b, m), m);
				end
				mau_pkg::OP_INV: begin
					if (a == 0) err = 1'b1;
					else res = invmod(a, m);
				end
				mau_pkg::OP_POW: begin
					if (w[63]) begin
						if (a == 0) err = 1'b1;
						else res = powmod(invmod(a, m), 64'd0 - w, m);
					end else begin
						res = powmod(a, w, m);
					end
				end
				mau_pkg::OP_NEG: res = (a == 0) ? 0 : m - a;
				mau_pkg::OP_INC: res = (a + 1 >= m) ? 0 : a + 1;
				mau_pkg::OP_DEC: res = (a == 0) ? m - 1 : a - 1;
				mau_pkg::OP_REDS: begin
					if (w[63]) begin
						r = (64'd0 - w) % m;
						res = (r == 0) ? 0 : m - r;
					end else begin
						res = w % m;
					end
				end
				default: res = w % m;
			endcase
		end
		if (err) res = 0;
		p.residue = res[30:0];
		p.error = err;
		return p;
	endfunction

	function void record_command(mau_pkg::cmd_t c, logic [30:0] modulus);
		expected_q.push_back(predict(c, modulus));
	endfunction

	function void check_result(mau_pkg::rsp_t got);
		mau_pkg::rsp_t exp_r;
		if (expected_q.size() == 0) begin
			$error("unexpected result: residue %0d error %0b", got.residue, got.error);
			failures++;
			return;
		end
		exp_r = expected_q.pop_front();
		if (got.residue !== exp_r.residue) begin
			$error("residue: expected %0d, got %0d", exp_r.residue, got.residue);
			failures++;
		end
		if (got.error !== exp_r.error) begin
			$error("error: expected %0b, got %0b", exp_r.error, got.error);
			failures++;
		end
	endfunction
endclass

module tb;
	localparam int unsigned STALL_LIMIT = 2000000;
	localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	mau_pkg::cmd_t cmd;
	logic          done;
	mau_pkg::rsp_t rsp;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [30:0]   cfg_data;

	logic [30:0] cur_modulus;
	int unsigned idle_cycles;
	bit          no_gaps;
	residue_scoreboard sb;

	modular_arithmetic_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(rsp);
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL modular_arithmetic_unit");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int unsigned pick_gap();
		if (no_gaps) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 1) == 0) return 0;
		return $urandom_range(1, 3);
	endfunction

	task automatic send_command(mau_pkg::cmd_t c);
		int unsigned gap;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!(start && !busy));
		sb.record_command(c, cur_modulus);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_modulus(logic [30:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cur_modulus = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic mau_pkg::cmd_t make_cmd(logic [3:0] op, logic [30:0] a,
			logic [30:0] b, logic [63:0] w);
		mau_pkg::cmd_t c;
		c.op = op;
		c.left_operand = a;
		c.right_operand = b;
		c.wide_value = w;
		return c;
	endfunction

	function automatic logic [30:0] rand_residue();
		if (cur_modulus == '0 || $urandom_range(0, 24) == 0) return 31'($urandom);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return cur_modulus - 31'd1;
			2: return 31'd1;
			default: return 31'($urandom % cur_modulus);
		endcase
	endfunction

	function automatic logic [63:0] rand_wide(bit for_power);
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return MOST_NEG;
			1: return {1'b0, {63{1'b1}}};
			2: return 64'($urandom_range(0, 20));
			3: return 64'd0 - 64'($urandom_range(1, 20));
			default: return for_power && $urandom_range(0, 1) ? 64'($urandom) : w;
		endcase
	endfunction

	function automatic mau_pkg::cmd_t rand_cmd();
		logic [3:0] op;
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 4) op = 4'($urandom_range(11, 15));
		else if (k < 10) op = mau_pkg::OP_DIV;
		else if (k < 15) op = mau_pkg::OP_INV;
		else if (k < 20) op = mau_pkg::OP_POW;
		else op = 4'($urandom_range(0, 10));
		return make_cmd(op, rand_residue(), rand_residue(),
			rand_wide(op == mau_pkg::OP_POW));
	endfunction

	task automatic run_random(int unsigned count);
		repeat (count) begin
			if ($urandom_range(0, 39) == 0) no_gaps = ~no_gaps;
			send_command(rand_cmd());
		end
	endtask

	initial begin
		logic [30:0] mx;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		sb = new();
		cur_modulus = mau_pkg::MODULUS_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		mx = mau_pkg::MODULUS_RESET - 31'd1;
		send_command(make_cmd(mau_pkg::OP_ADD, mx, mx, '0));
		send_command(make_cmd(mau_pkg::OP_SUB, '0, mx, '1));
		send_command(make_cmd(mau_pkg::OP_MUL, mx, mx, '0));
		send_command(make_cmd(mau_pkg::OP_DIV, 31'd5, '0, '0));
		send_command(make_cmd(mau_pkg::OP_DIV, mx, 31'd3, '0));
		send_command(make_cmd(mau_pkg::OP_INV, '0, '0, '0));
		send_command(make_cmd(mau_pkg::OP_INV, 31'd1, '0, '0));
		send_command(make_cmd(mau_pkg::OP_INV, mx, '0, '0));
		send_command(make_cmd(mau_pkg::OP_POW, '0, '0, '0));
		send_command(make_cmd(mau_pkg::OP_POW, '0, '0, '1));
		send_command(make_cmd(mau_pkg::OP_POW, 31'd2, '0, MOST_NEG));
		send_command(make_cmd(mau_pkg::OP_POW, mx, '0, {1'b0, {63{1'b1}}}));
		send_command(make_cmd(mau_pkg::OP_NEG, '0, '0, '0));
		send_command(make_cmd(mau_pkg::OP_NEG, mx, '0, '0));
		send_command(make_cmd(mau_pkg::OP_INC, mx, '0, '0));
		send_command(make_cmd(mau_pkg::OP_DEC, '0, '0, '0));
		send_command(make_cmd(mau_pkg::OP_REDS, '0, '0, MOST_NEG));
		send_command(make_cmd(mau_pkg::OP_REDS, '0, '0, '1));
		send_command(make_cmd(mau_pkg::OP_REDS, '0, '0, {1'b0, {63{1'b1}}}));
		send_command(make_cmd(mau_pkg::OP_REDU, '1, '1, '1));
		send_command(make_cmd(mau_pkg::OP_ADD, mau_pkg::MODULUS_RESET, '0, '0));
		send_command(make_cmd(mau_pkg::OP_SUB, '0, '1, '0));
		send_command(make_cmd(mau_pkg::OP_INV, '1, '0, '0));
		// unused opcodes
		send_command(make_cmd(4'd11, 31'd1, 31'd1, '0));
		send_command(make_cmd(4'd15, '1, '1, '1));

		run_random(200);
		// hold off until all results are back, then continue at the same modulus
		wait_drained();
		run_random(50);
		write_modulus(31'h7fff_ffff);
		run_random(200);
		write_modulus(31'd7);
		run_random(120);
		write_modulus(31'd2);
		run_random(80);
		write_modulus(31'd1);
		run_random(60);
		write_modulus(31'd0);
		run_random(50);
		write_modulus(31'd1000);
		run_random(120);
		write_modulus(31'd65537);
		run_random(120);
		write_modulus(mau_pkg::MODULUS_RESET);
		run_random(150);

		wait_drained();
		repeat (50) @(posedge clk);
		if (sb.failures == 0 && sb.expected_q.size() == 0) begin
			$display("PASS modular_arithmetic_unit");
		end else begin
			$display("FAIL modular_arithmetic_unit");
		end
		$finish;
	end
endmodule
